### rtl/core/opwm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths, arctangent table and pipeline structs for the
// omnidirectional pixel to world mapper. No dependencies.
package opwm_pkg;

    localparam int PIXEL_BITS    = 10;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NS            = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int SIW           = 5;

    localparam int CENTER_W = 14;
    localparam int DW       = ((PIXEL_BITS + 4 > CENTER_W) ? PIXEL_BITS + 4 : CENTER_W) + 1;
    localparam int SQW      = 2 * DW - 2;
    localparam int NW       = 2 * DW + 7;
    localparam int RW       = (NW + 1) / 2;
    localparam int CW       = DW + 21;
    localparam int ZW       = 35;
    localparam int THW      = 24 + RW;
    localparam int XDW      = 26;
    localparam int QW       = 16;
    localparam int DIVW     = 58;

    localparam logic [32:0] HALF_PI_Q32      = 33'd6746518853;
    localparam logic [29:0] TURN_PER_RAD_Q32 = 30'd683565276;
    localparam logic [29:0] INV_GAIN_Q30     = 30'd652032874;

    localparam logic [31:0] ATAN_TURN [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 zero;
        logic [RW-1:0]        r;
        logic [15:0]          rel;
        logic                 hor;
        logic                 xpos;
        logic                 sat;
        logic [QW-1:0]        gdist;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cord;

    typedef struct packed {
        logic [NW:0] rem;
        logic [NW:0] res;
    } t_sqrt;

    typedef struct packed {
        logic [DIVW-1:0] rem;
        logic [XDW-1:0]  den;
        logic [QW-1:0]   q;
    } t_div;

endpackage

### rtl/core/opwm_cordic_cell.sv
`timescale 1ns / 1ps
// One registered CORDIC micro-rotation, vectoring or rotation mode.
// Depends on opwm_pkg.
module opwm_cordic_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vec,
    input  logic [opwm_pkg::SIW-1:0]   i_stage,
    input  logic                       i_vld,
    input  opwm_pkg::t_cord            i_cord,
    input  opwm_pkg::t_side            i_side,
    output logic                       o_vld,
    output opwm_pkg::t_cord            o_cord,
    output opwm_pkg::t_side            o_side
);
    import opwm_pkg::*;

    logic signed [CW-1:0] x, y, xs, ys;
    logic signed [ZW-1:0] z, at;
    logic                 ccw;
    t_cord                n_cord;
    logic                 r_vld;
    t_cord                r_cord;
    t_side                r_side;

    always_comb begin
        x   = i_cord.x;
        y   = i_cord.y;
        z   = i_cord.z;
        xs  = x >>> i_stage;
        ys  = y >>> i_stage;
        at  = signed'(ZW'(ATAN_TURN[i_stage]));
        ccw = i_vec ? !(y > 0) : !z[ZW-1];
        if (ccw) begin
            n_cord.x = x - ys;
            n_cord.y = y + xs;
            n_cord.z = z - at;
        end else begin
            n_cord.x = x + ys;
            n_cord.y = y - xs;
            n_cord.z = z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_cord <= n_cord;
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_cord = r_cord;
    assign o_side = r_side;

endmodule

### rtl/core/opwm_sqrt_cell.sv
`timescale 1ns / 1ps
// One registered digit step of the integer square root.
// Depends on opwm_pkg.
module opwm_sqrt_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [opwm_pkg::SIW-1:0]   i_stage,
    input  logic                       i_vld,
    input  opwm_pkg::t_sqrt            i_sq,
    input  opwm_pkg::t_side            i_side,
    output logic                       o_vld,
    output opwm_pkg::t_sqrt            o_sq,
    output opwm_pkg::t_side            o_side
);
    import opwm_pkg::*;

    logic [NW:0] bit_v, trial;
    t_sqrt       n_sq;
    logic        r_vld;
    t_sqrt       r_sq;
    t_side       r_side;

    always_comb begin
        bit_v = {{NW{1'b0}}, 1'b1} << {i_stage, 1'b0};
        trial = i_sq.res + bit_v;
        if (i_sq.rem >= trial) begin
            n_sq.rem = i_sq.rem - trial;
            n_sq.res = (i_sq.res >> 1) + bit_v;
        end else begin
            n_sq.rem = i_sq.rem;
            n_sq.res = i_sq.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_sq   <= n_sq;
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_sq   = r_sq;
    assign o_side = r_side;

endmodule

### rtl/core/opwm_div_cell.sv
`timescale 1ns / 1ps
// One registered quotient bit of the restoring distance divider.
// Depends on opwm_pkg.
module opwm_div_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [opwm_pkg::SIW-1:0]   i_stage,
    input  logic                       i_vld,
    input  opwm_pkg::t_div             i_dv,
    input  opwm_pkg::t_side            i_side,
    output logic                       o_vld,
    output opwm_pkg::t_div             o_dv,
    output opwm_pkg::t_side            o_side
);
    import opwm_pkg::*;

    logic [DIVW-1:0] sub;
    t_div            n_dv;
    logic            r_vld;
    t_div            r_dv;
    t_side           r_side;

    // divisor is den << 16, so this step subtracts den << (16 + k)
    always_comb begin
        sub      = DIVW'(i_dv.den) << (i_stage + 5'd16);
        n_dv.den = i_dv.den;
        if (i_dv.rem >= sub) begin
            n_dv.rem = i_dv.rem - sub;
            n_dv.q   = {i_dv.q[QW-2:0], 1'b1};
        end else begin
            n_dv.rem = i_dv.rem;
            n_dv.q   = {i_dv.q[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_dv   <= n_dv;
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_dv   = r_dv;
    assign o_side = r_side;

endmodule

### rtl/core/omni_pixel_to_world_mapper.sv
`timescale 1ns / 1ps
// Top level: pixel to floor position mapping pipeline.
// Depends on opwm_pkg, opwm_sqrt_cell, opwm_cordic_cell, opwm_div_cell.
//
// Fully pipelined: one item may start in every cycle and busy never rises.
// Each item passes through registered stages s1 to s3, the chain of RW
// square-root cells, s4, three CORDIC chains of NS cells (vectoring, then
// tangent after s5 and s6, then world rotation after s8, s9, the 16-cell
// divider, s10 and s11) and the s12 output register. Results are shown for
// one cycle only and cannot be held off. Configuration writes take effect
// at once; write only while no item is in flight.
module omni_pixel_to_world_mapper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [opwm_pkg::PIXEL_BITS-1:0]   i_pixel_x,
    input  logic [opwm_pkg::PIXEL_BITS-1:0]   i_pixel_y,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [31:0]                       i_cfg_data,
    output logic                              o_valid,
    output logic [15:0]                       o_rel_angle,
    output logic [15:0]                       o_rel_distance,
    output logic signed [15:0]                o_world_x,
    output logic signed [15:0]                o_world_y,
    output logic                              o_saturated
);
    import opwm_pkg::*;

    localparam logic [2:0] CFG_CENTER_X   = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [2:0] CFG_ROBOT_X    = 3'd2;
    localparam logic [2:0] CFG_ROBOT_Y    = 3'd3;
    localparam logic [2:0] CFG_HEADING    = 3'd4;
    localparam logic [2:0] CFG_LENS_SCALE = 3'd5;
    localparam logic [2:0] CFG_ANGLE_GAIN = 3'd6;

    // configuration
    logic [13:0]        r_center_x, r_center_y;
    logic signed [15:0] r_robot_x, r_robot_y;
    logic [15:0]        r_heading;
    logic [31:0]        r_lens_scale;
    logic [23:0]        r_angle_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_robot_x    <= '0;
            r_robot_y    <= '0;
            r_heading    <= '0;
            r_lens_scale <= 32'd11382582;
            r_angle_gain <= 24'd117925;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X:   r_center_x   <= i_cfg_data[13:0];
                CFG_CENTER_Y:   r_center_y   <= i_cfg_data[13:0];
                CFG_ROBOT_X:    r_robot_x    <= signed'(i_cfg_data[15:0]);
                CFG_ROBOT_Y:    r_robot_y    <= signed'(i_cfg_data[15:0]);
                CFG_HEADING:    r_heading    <= i_cfg_data[15:0];
                CFG_LENS_SCALE: r_lens_scale <= i_cfg_data;
                CFG_ANGLE_GAIN: r_angle_gain <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // s1: offset from mirror center
    logic  r_s1_vld;
    t_side n_s1_side, r_s1_side;

    always_comb begin
        n_s1_side    = '0;
        n_s1_side.dx = DW'({i_pixel_x, 4'b0000}) - DW'(r_center_x);
        n_s1_side.dy = DW'({i_pixel_y, 4'b0000}) - DW'(r_center_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start;
        end
        r_s1_side <= n_s1_side;
    end

    // s2: squares
    logic                   r_s2_vld;
    t_side                  r_s2_side;
    logic signed [2*DW-1:0] n_px, n_py;
    logic [SQW-1:0]         r_s2_sqx, r_s2_sqy;

    always_comb begin
        n_px = r_s1_side.dx * r_s1_side.dx;
        n_py = r_s1_side.dy * r_s1_side.dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_side <= r_s1_side;
        r_s2_sqx  <= n_px[SQW-1:0];
        r_s2_sqy  <= n_py[SQW-1:0];
    end

    // s3: squared radius in 1/65536 pixel^2
    logic          r_s3_vld;
    t_side         r_s3_side;
    logic [SQW:0]  n_sum;
    logic [NW-1:0] r_s3_n;

    assign n_sum = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_side <= r_s2_side;
        r_s3_n    <= {n_sum, 8'h00};
    end

    // square root chain
    logic [RW:0] sq_v;
    t_sqrt       sq_d [RW+1];
    t_side       sq_s [RW+1];

    assign sq_v[0] = r_s3_vld;
    assign sq_d[0] = '{rem: {1'b0, r_s3_n}, res: '0};
    assign sq_s[0] = r_s3_side;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        opwm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (SIW'(RW - 1 - g)),
            .i_vld   (sq_v[g]),
            .i_sq    (sq_d[g]),
            .i_side  (sq_s[g]),
            .o_vld   (sq_v[g+1]),
            .o_sq    (sq_d[g+1]),
            .o_side  (sq_s[g+1])
        );
    end

    // s4: vectoring start
    logic                 r_s4_vld;
    t_side                n_s4_side, r_s4_side;
    t_cord                n_s4_cord, r_s4_cord;
    logic signed [CW-1:0] ex, ey;

    always_comb begin
        n_s4_side      = sq_s[RW];
        n_s4_side.r    = sq_d[RW].res[RW-1:0];
        n_s4_side.zero = (sq_s[RW].dx == '0) && (sq_s[RW].dy == '0);
        ex = CW'(sq_s[RW].dx) <<< 16;
        ey = CW'(sq_s[RW].dy) <<< 16;
        if (ex < 0) begin
            n_s4_cord.x = -ex;
            n_s4_cord.y = -ey;
            n_s4_cord.z = signed'({{(ZW-32){1'b0}}, 32'h8000_0000});
        end else begin
            n_s4_cord.x = ex;
            n_s4_cord.y = ey;
            n_s4_cord.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= sq_v[RW];
        end
        r_s4_side <= n_s4_side;
        r_s4_cord <= n_s4_cord;
    end

    // vectoring chain: offset angle
    logic [NS:0] vc_v;
    t_cord       vc_c [NS+1];
    t_side       vc_s [NS+1];

    assign vc_v[0] = r_s4_vld;
    assign vc_c[0] = r_s4_cord;
    assign vc_s[0] = r_s4_side;

    for (genvar g = 0; g < NS; g++) begin : g_vec
        opwm_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vec   (1'b1),
            .i_stage (SIW'(g)),
            .i_vld   (vc_v[g]),
            .i_cord  (vc_c[g]),
            .i_side  (vc_s[g]),
            .o_vld   (vc_v[g+1]),
            .o_cord  (vc_c[g+1]),
            .o_side  (vc_s[g+1])
        );
    end

    // s5: relative angle and tan argument
    logic                 r_s5_vld;
    t_side                n_s5_side, r_s5_side;
    logic signed [ZW-1:0] zr;
    logic [THW-1:0]       r_s5_theta;

    always_comb begin
        zr            = (vc_s[NS].zero ? '0 : vc_c[NS].z) + ZW'(32768);
        n_s5_side     = vc_s[NS];
        n_s5_side.rel = zr[31:16] + r_heading;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= vc_v[NS];
        end
        r_s5_side  <= n_s5_side;
        r_s5_theta <= THW'(r_angle_gain) * THW'(vc_s[NS].r);
    end

    // s6: horizon check, radians to turns
    logic        r_s6_vld;
    t_side       n_s6_side, r_s6_side;
    logic [62:0] r_s6_tp;
    logic [63:0] tr;

    always_comb begin
        n_s6_side     = r_s5_side;
        n_s6_side.hor = r_s5_theta >= THW'(HALF_PI_Q32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
        r_s6_side <= n_s6_side;
        r_s6_tp   <= 63'(r_s5_theta[32:0]) * 63'(TURN_PER_RAD_Q32);
    end

    assign tr = {1'b0, r_s6_tp} + 64'h0000_0000_8000_0000;

    // tangent chain
    logic [NS:0] tn_v;
    t_cord       tn_c [NS+1];
    t_side       tn_s [NS+1];

    assign tn_v[0] = r_s6_vld;
    assign tn_c[0] = '{x: signed'({{(CW-25){1'b0}}, 1'b1, 24'h0}), y: '0,
                       z: signed'(ZW'(tr[63:32]))};
    assign tn_s[0] = r_s6_side;

    for (genvar g = 0; g < NS; g++) begin : g_tan
        opwm_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vec   (1'b0),
            .i_stage (SIW'(g)),
            .i_vld   (tn_v[g]),
            .i_cord  (tn_c[g]),
            .i_side  (tn_s[g]),
            .o_vld   (tn_v[g+1]),
            .o_cord  (tn_c[g+1]),
            .o_side  (tn_s[g+1])
        );
    end

    // s8: numerator product
    logic            r_s8_vld;
    t_side           n_s8_side, r_s8_side;
    logic [XDW-1:0]  yc;
    logic [DIVW-1:0] r_s8_num;
    logic [XDW-1:0]  r_s8_den;

    always_comb begin
        n_s8_side      = tn_s[NS];
        n_s8_side.xpos = tn_c[NS].x > 0;
        yc = tn_c[NS].y[CW-1] ? '0 : tn_c[NS].y[XDW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
        end else begin
            r_s8_vld <= tn_v[NS];
        end
        r_s8_side <= n_s8_side;
        r_s8_num  <= DIVW'(r_lens_scale) * DIVW'(yc);
        r_s8_den  <= tn_c[NS].x[XDW-1:0];
    end

    // s9: rounding bias and overflow check
    logic            r_s9_vld;
    t_side           n_s9_side, r_s9_side;
    logic [DIVW-1:0] nn;
    t_div            r_s9_dv;

    always_comb begin
        nn            = r_s8_num + (DIVW'(r_s8_den) << 15);
        n_s9_side     = r_s8_side;
        n_s9_side.sat = r_s8_side.hor || !r_s8_side.xpos
                        || (nn >= (DIVW'(r_s8_den) << 32));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_vld <= 1'b0;
        end else begin
            r_s9_vld <= r_s8_vld;
        end
        r_s9_side <= n_s9_side;
        r_s9_dv   <= '{rem: nn, den: r_s8_den, q: '0};
    end

    // divider chain
    logic [QW:0] dv_v;
    t_div        dv_d [QW+1];
    t_side       dv_s [QW+1];

    assign dv_v[0] = r_s9_vld;
    assign dv_d[0] = r_s9_dv;
    assign dv_s[0] = r_s9_side;

    for (genvar g = 0; g < QW; g++) begin : g_div
        opwm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (SIW'(QW - 1 - g)),
            .i_vld   (dv_v[g]),
            .i_dv    (dv_d[g]),
            .i_side  (dv_s[g]),
            .o_vld   (dv_v[g+1]),
            .o_dv    (dv_d[g+1]),
            .o_side  (dv_s[g+1])
        );
    end

    // s10: distance and magnitude product
    logic        r_s10_vld;
    t_side       n_s10_side, r_s10_side;
    logic [45:0] r_s10_mp;

    always_comb begin
        n_s10_side       = dv_s[QW];
        n_s10_side.gdist = dv_s[QW].sat ? {QW{1'b1}} : dv_d[QW].q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_vld <= 1'b0;
        end else begin
            r_s10_vld <= dv_v[QW];
        end
        r_s10_side <= n_s10_side;
        r_s10_mp   <= 46'(n_s10_side.gdist) * 46'(INV_GAIN_Q30);
    end

    // s11: quadrant fold for the world rotation
    logic                 r_s11_vld;
    t_side                r_s11_side;
    t_cord                n_s11_cord, r_s11_cord;
    logic signed [ZW-1:0] a;
    logic signed [CW-1:0] mag;

    always_comb begin
        a   = ZW'(signed'({r_s10_side.rel, 16'h0000}));
        mag = signed'(CW'(r_s10_mp[45:14]));
        n_s11_cord.y = '0;
        if (a > signed'(ZW'(32'h4000_0000))) begin
            n_s11_cord.z = a - signed'(ZW'(32'h8000_0000));
            n_s11_cord.x = -mag;
        end else if (a < -signed'(ZW'(32'h4000_0000))) begin
            n_s11_cord.z = a + signed'(ZW'(32'h8000_0000));
            n_s11_cord.x = -mag;
        end else begin
            n_s11_cord.z = a;
            n_s11_cord.x = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s11_vld <= 1'b0;
        end else begin
            r_s11_vld <= r_s10_vld;
        end
        r_s11_side <= r_s10_side;
        r_s11_cord <= n_s11_cord;
    end

    // world rotation chain
    logic [NS:0] wr_v;
    t_cord       wr_c [NS+1];
    t_side       wr_s [NS+1];

    assign wr_v[0] = r_s11_vld;
    assign wr_c[0] = r_s11_cord;
    assign wr_s[0] = r_s11_side;

    for (genvar g = 0; g < NS; g++) begin : g_world
        opwm_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vec   (1'b0),
            .i_stage (SIW'(g)),
            .i_vld   (wr_v[g]),
            .i_cord  (wr_c[g]),
            .i_side  (wr_s[g]),
            .o_vld   (wr_v[g+1]),
            .o_cord  (wr_c[g+1]),
            .o_side  (wr_s[g+1])
        );
    end

    // s12: world position, clip, output
    logic                 r_out_vld;
    logic signed [CW-1:0] xr, yr, wsx, wsy;
    logic signed [15:0]   n_wx, n_wy;
    logic                 n_sat;
    logic [15:0]          r_out_rel, r_out_dist;
    logic signed [15:0]   r_out_wx, r_out_wy;
    logic                 r_out_sat;

    always_comb begin
        xr    = wr_c[NS].x + CW'(32768);
        yr    = wr_c[NS].y + CW'(32768);
        wsx   = CW'(r_robot_x) + (xr >>> 16);
        wsy   = CW'(r_robot_y) + (yr >>> 16);
        n_sat = wr_s[NS].sat;
        if (wsx > CW'(32767)) begin
            n_wx  = 16'sh7FFF;
            n_sat = 1'b1;
        end else if (wsx < -CW'(32768)) begin
            n_wx  = -16'sh8000;
            n_sat = 1'b1;
        end else begin
            n_wx = wsx[15:0];
        end
        if (wsy > CW'(32767)) begin
            n_wy  = 16'sh7FFF;
            n_sat = 1'b1;
        end else if (wsy < -CW'(32768)) begin
            n_wy  = -16'sh8000;
            n_sat = 1'b1;
        end else begin
            n_wy = wsy[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= wr_v[NS];
        end
        r_out_rel  <= wr_s[NS].rel;
        r_out_dist <= wr_s[NS].gdist;
        r_out_wx   <= n_wx;
        r_out_wy   <= n_wy;
        r_out_sat  <= n_sat;
    end

    assign o_valid        = r_out_vld;
    assign o_rel_angle    = r_out_rel;
    assign o_rel_distance = r_out_dist;
    assign o_world_x      = r_out_wx;
    assign o_world_y      = r_out_wy;
    assign o_saturated    = r_out_sat;

endmodule
